[rtl/lossless_image_pixel_predictor_macros.svh]
// assertion macros shared by the predictor rtl
`ifndef LOSSLESS_IMAGE_PIXEL_PREDICTOR_MACROS_SVH
`define LOSSLESS_IMAGE_PIXEL_PREDICTOR_MACROS_SVH

// implication checked at every clock edge outside reset
`define LIPP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition that must never hold outside reset
`define LIPP_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

[rtl/lipp_pkg.sv]
// shared constants for the pixel predictor
package lipp_pkg;

  localparam int MAX_WIDTH = 4096;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int PIX_W     = 8;
  localparam int MODE_W    = 4;
  localparam int IWIDTH_W  = 13;
  localparam int CFG_W     = 13;

  // configuration register indexes
  localparam logic REG_MODE  = 1'b0;
  localparam logic REG_WIDTH = 1'b1;

  // predictor modes
  localparam logic [MODE_W-1:0] MODE_IDENTITY   = 4'd0;
  localparam logic [MODE_W-1:0] MODE_LEFT       = 4'd1;
  localparam logic [MODE_W-1:0] MODE_ABOVE      = 4'd2;
  localparam logic [MODE_W-1:0] MODE_UPPER_LEFT = 4'd3;
  localparam logic [MODE_W-1:0] MODE_PLANE      = 4'd4;
  localparam logic [MODE_W-1:0] MODE_A_HALF_BC  = 4'd5;
  localparam logic [MODE_W-1:0] MODE_B_HALF_AC  = 4'd6;
  localparam logic [MODE_W-1:0] MODE_AVERAGE    = 4'd7;
  localparam logic [MODE_W-1:0] MODE_MED        = 4'd8;

  localparam logic [MODE_W-1:0]   MODE_RESET  = MODE_MED;
  localparam logic [IWIDTH_W-1:0] WIDTH_RESET = 13'd256;

endpackage

[rtl/lipp_line_buf.sv]
// previous-row line store, single port, read-first, registered read
module lipp_line_buf (
  input  logic                      clk,
  input  logic                      en,
  input  logic [lipp_pkg::COL_W-1:0] addr,
  input  logic [lipp_pkg::PIX_W-1:0] wdata,
  output logic [lipp_pkg::PIX_W-1:0] rdata
);
  import lipp_pkg::*;

  logic [PIX_W-1:0] mem [MAX_WIDTH];

  // old contents come out while the new pixel goes in
  always_ff @(posedge clk) begin
    if (en) begin
      rdata     <= mem[addr];
      mem[addr] <= wdata;
    end
  end

endmodule

[rtl/lossless_image_pixel_predictor.sv]
// Lossless image pixel predictor: takes 8-bit pixels in raster order and returns one
// prediction per pixel (lossless JPEG predictors 0-7 or the JPEG-LS median edge
// detector, chosen by predictor_mode). One pixel is taken every clock cycle unless
// in_stall is high. Its prediction is registered first by the line store read, which
// returns the pixel above from the single port while the current pixel is written into
// its place, alongside stage 1, and then by the output register behind the predictor. A
// stalled output holds the result and stalls the input only once stage 1 is also full.
// The line store needs no clearing after reset; the first row of each image reads its
// upper neighbors as 0. Write configuration only while no pixel is in flight.
`include "lossless_image_pixel_predictor_macros.svh"

module lossless_image_pixel_predictor (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write_enable,
  input  logic                          cfg_index,
  input  logic [lipp_pkg::CFG_W-1:0]    cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [lipp_pkg::PIX_W-1:0]    pixel,
  input  logic                          first_of_image,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [lipp_pkg::PIX_W-1:0]    prediction
);
  import lipp_pkg::*;

  logic [MODE_W-1:0]   predictor_mode;
  logic [IWIDTH_W-1:0] image_width;

  logic [COL_W-1:0] column;
  logic             on_first_row;
  logic [PIX_W-1:0] left_pixel;
  logic [PIX_W-1:0] upper_left_pixel;

  logic             s1_valid;
  logic [PIX_W-1:0] s1_pixel;
  logic [PIX_W-1:0] s1_left;
  logic             s1_col_nz;
  logic             s1_first_row;

  logic [PIX_W-1:0] above;
  logic [PIX_W-1:0] prediction_next;

  logic             accept;
  logic             s1_advance;
  logic [COL_W-1:0] x;
  logic             row_first;
  logic [IWIDTH_W-1:0] eff_width;
  logic [IWIDTH_W-1:0] x_inc;
  logic             row_end;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      predictor_mode <= MODE_RESET;
      image_width    <= WIDTH_RESET;
    end else if (cfg_write_enable) begin
      case (cfg_index)
        REG_MODE:  predictor_mode <= cfg_data[MODE_W-1:0];
        REG_WIDTH: image_width    <= cfg_data[IWIDTH_W-1:0];
        default:   ;
      endcase
    end
  end

  // handshake
  assign s1_advance = s1_valid && (!out_valid || !out_stall);
  assign in_stall   = s1_valid && !s1_advance;
  assign accept     = in_valid && !in_stall;

  // column bookkeeping at the input transfer
  always_comb begin
    x         = first_of_image ? '0 : column;
    row_first = first_of_image ? 1'b1 : on_first_row;
    eff_width = image_width;
    if (eff_width == '0) begin
      eff_width = IWIDTH_W'(1);
    end else if (eff_width > IWIDTH_W'(MAX_WIDTH)) begin
      eff_width = IWIDTH_W'(MAX_WIDTH);
    end
    x_inc   = IWIDTH_W'(x) + IWIDTH_W'(1);
    row_end = x_inc >= eff_width;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column       <= '0;
      on_first_row <= 1'b1;
      left_pixel   <= '0;
    end else if (accept) begin
      left_pixel <= pixel;
      if (row_end) begin
        column       <= '0;
        on_first_row <= 1'b0;
      end else begin
        column       <= x_inc[COL_W-1:0];
        on_first_row <= row_first;
      end
    end
  end

  lipp_line_buf u_line_buf (
    .clk   (clk),
    .en    (accept),
    .addr  (x),
    .wdata (pixel),
    .rdata (above)
  );

  // stage 1 waits on the line store read
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pixel     <= pixel;
      s1_left      <= left_pixel;
      s1_col_nz    <= (x != '0);
      s1_first_row <= row_first;
    end
  end

  // upper-left is the previous pixel's above value
  always_ff @(posedge clk) begin
    if (rst) begin
      upper_left_pixel <= '0;
    end else if (s1_advance) begin
      upper_left_pixel <= above;
    end
  end

  // prediction
  always_comb begin
    logic [PIX_W-1:0]  a_u, b_u, c_u, hi, lo;
    logic signed [9:0] a, b, c, d, half, r;
    a_u  = s1_col_nz ? s1_left : '0;
    b_u  = s1_first_row ? '0 : above;
    c_u  = (s1_col_nz && !s1_first_row) ? upper_left_pixel : '0;
    hi   = (a_u > b_u) ? a_u : b_u;
    lo   = (a_u < b_u) ? a_u : b_u;
    a    = signed'({2'b00, a_u});
    b    = signed'({2'b00, b_u});
    c    = signed'({2'b00, c_u});
    d    = '0;
    half = '0;
    case (predictor_mode)
      MODE_IDENTITY:   r = signed'({2'b00, s1_pixel});
      MODE_LEFT:       r = a;
      MODE_ABOVE:      r = b;
      MODE_UPPER_LEFT: r = c;
      MODE_PLANE:      r = a + b - c;
      MODE_A_HALF_BC: begin
        d    = b - c;
        // halve rounding toward zero
        half = (d + signed'({9'd0, d[9]})) >>> 1;
        r    = a + half;
      end
      MODE_B_HALF_AC: begin
        d    = a - c;
        half = (d + signed'({9'd0, d[9]})) >>> 1;
        r    = b + half;
      end
      MODE_AVERAGE:    r = (a + b) >>> 1;
      MODE_MED: begin
        if (c_u >= hi) begin
          r = signed'({2'b00, lo});
        end else if (c_u <= lo) begin
          r = signed'({2'b00, hi});
        end else begin
          r = a + b - c;
        end
      end
      default:         r = '0;
    endcase
    prediction_next = r[PIX_W-1:0];
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      prediction <= prediction_next;
    end
  end

  `LIPP_ASSERT(a_empty_no_stall, !s1_valid |-> !in_stall, "input stalled with stage 1 empty")
  `LIPP_ASSERT(a_accept_fills, accept |=> s1_valid, "transfer did not reach stage 1")
  `LIPP_ASSERT(a_first_restart, (accept && first_of_image) |=> (!s1_col_nz && s1_first_row),
    "first of image did not restart row and column")
  `LIPP_ASSERT(a_advance_fills_out, s1_advance |=> out_valid, "stage 1 result lost")

endmodule
